[src/degeneracy_hysteresis_monitor_macros.svh]
// assertion helpers used by the top-level monitor
`ifndef DEGENERACY_HYSTERESIS_MONITOR_MACROS_SVH
`define DEGENERACY_HYSTERESIS_MONITOR_MACROS_SVH

// condition on this edge implies a consequence on the same edge
`define DHM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition on this edge implies a consequence on the next edge
`define DHM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/dhm_pkg.sv]
`default_nettype none

package dhm_pkg;

  // parameter defaults
  localparam int VALUE_WIDTH_DEF    = 32;
  localparam int STAGNATION_EPS_DEF = 1;

  // fixed field widths
  localparam int STAMP_W   = 32;
  localparam int DWELL_W   = 32;
  localparam int COUNT_W   = 8;
  localparam int HEALTH_W  = 2;
  localparam int CFG_IDX_W = 3;

  // register reset values, Q23.8 thresholds
  localparam int LOW_X_RST  = 10240;
  localparam int LOW_Y_RST  = 10240;
  localparam int LOW_Z_RST  = 17920;
  localparam int HIGH_X_RST = 15360;
  localparam int HIGH_Y_RST = 15360;
  localparam int HIGH_Z_RST = 23040;
  localparam logic [DWELL_W-1:0] DWELL_RST = 32'd400000;
  localparam logic [COUNT_W-1:0] LIMIT_RST = 8'd5;

  // x must exceed 0.1 (25.6 lsb) for a sample to count as stagnant
  localparam int X_MIN_LSB = 25;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_X            = 3'd0,
    CFG_LOW_Y            = 3'd1,
    CFG_LOW_Z            = 3'd2,
    CFG_HIGH_X           = 3'd3,
    CFG_HIGH_Y           = 3'd4,
    CFG_HIGH_Z           = 3'd5,
    CFG_DWELL_US         = 3'd6,
    CFG_STAGNATION_LIMIT = 3'd7
  } cfg_idx_t;

  // per-sample conditions handed to the health machine
  typedef struct packed {
    logic degen;
    logic recov;
  } cond_t;

endpackage

`default_nettype wire

[src/dhm_in_if.sv]
`default_nettype none

interface dhm_in_if #(
  parameter int VALUE_WIDTH = dhm_pkg::VALUE_WIDTH_DEF
);
  logic                                valid;
  logic                                ready;
  logic signed [VALUE_WIDTH-1:0]       eigen_x;
  logic signed [VALUE_WIDTH-1:0]       eigen_y;
  logic signed [VALUE_WIDTH-1:0]       eigen_z;
  logic        [dhm_pkg::STAMP_W-1:0]  stamp_us;

  modport source (output valid, eigen_x, eigen_y, eigen_z, stamp_us, input ready);
  modport sink   (input valid, eigen_x, eigen_y, eigen_z, stamp_us, output ready);
endinterface

`default_nettype wire

[src/dhm_out_if.sv]
`default_nettype none

interface dhm_out_if;
  logic                          valid;
  logic                          ready;
  logic [dhm_pkg::HEALTH_W-1:0]  health;
  logic                          degenerated;
  logic                          recovered;

  modport source (output valid, health, degenerated, recovered, input ready);
  modport sink   (input valid, health, degenerated, recovered, output ready);
endinterface

`default_nettype wire

[src/dhm_cond.sv]
`default_nettype none

module dhm_cond #(
  parameter int VALUE_WIDTH    = dhm_pkg::VALUE_WIDTH_DEF,
  parameter int STAGNATION_EPS = dhm_pkg::STAGNATION_EPS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              step,
  input  wire logic signed [VALUE_WIDTH-1:0]     x,
  input  wire logic signed [VALUE_WIDTH-1:0]     y,
  input  wire logic signed [VALUE_WIDTH-1:0]     z,
  input  wire logic signed [VALUE_WIDTH-1:0]     low_x,
  input  wire logic signed [VALUE_WIDTH-1:0]     low_y,
  input  wire logic signed [VALUE_WIDTH-1:0]     low_z,
  input  wire logic signed [VALUE_WIDTH-1:0]     high_x,
  input  wire logic signed [VALUE_WIDTH-1:0]     high_y,
  input  wire logic signed [VALUE_WIDTH-1:0]     high_z,
  input  wire logic [dhm_pkg::COUNT_W-1:0]       stag_limit,
  output dhm_pkg::cond_t                         cond
);

  localparam logic [VALUE_WIDTH:0] EpsVal = (VALUE_WIDTH+1)'(STAGNATION_EPS);
  localparam logic signed [VALUE_WIDTH-1:0] XMin = VALUE_WIDTH'(dhm_pkg::X_MIN_LSB);

  logic signed [VALUE_WIDTH-1:0]   prev_x_r, prev_y_r, prev_z_r;
  logic [dhm_pkg::COUNT_W-1:0]     count_r, count_nxt;
  logic                            stagnant;

  // |a - b| < eps on a one-bit-wider difference
  function automatic logic near_val(input logic signed [VALUE_WIDTH-1:0] a,
                                    input logic signed [VALUE_WIDTH-1:0] b);
    logic signed [VALUE_WIDTH:0] d;
    logic        [VALUE_WIDTH:0] mag;
    d   = {a[VALUE_WIDTH-1], a} - {b[VALUE_WIDTH-1], b};
    mag = d[VALUE_WIDTH] ? $unsigned(-d) : $unsigned(d);
    return mag < EpsVal;
  endfunction

  // stagnation test and saturating run counter
  always_comb begin
    stagnant = near_val(x, prev_x_r) && near_val(y, prev_y_r) && near_val(z, prev_z_r);
    if (stagnant && (x > XMin)) begin
      count_nxt = (count_r == dhm_pkg::COUNT_MAX) ? count_r : count_r + 1'b1;
    end else begin
      count_nxt = '0;
    end
  end

  // degeneracy and recovery flags
  always_comb begin
    cond.degen = (x < low_x) || (y < low_y) || (z < low_z) || (count_nxt >= stag_limit);
    cond.recov = (x > high_x) && (y > high_y) && (z > high_z) && !stagnant;
  end

  // history of the previous sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r <= '0;
      prev_y_r <= '0;
      prev_z_r <= '0;
      count_r  <= '0;
    end else if (step) begin
      prev_x_r <= x;
      prev_y_r <= y;
      prev_z_r <= z;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

[src/dhm_health.sv]
`default_nettype none

module dhm_health (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              step,
  input  wire dhm_pkg::cond_t                    cond,
  input  wire logic [dhm_pkg::STAMP_W-1:0]       stamp_us,
  input  wire logic [dhm_pkg::DWELL_W-1:0]       dwell_us,
  output logic      [dhm_pkg::HEALTH_W-1:0]      health_nxt
);

  typedef enum logic [dhm_pkg::HEALTH_W-1:0] {
    HM_CONSISTENT   = 2'd0,
    HM_POT_INCONS   = 2'd1,
    HM_INCONSISTENT = 2'd2,
    HM_POT_CONS     = 2'd3
  } health_t;

  health_t                       mode_r, mode_nxt;
  logic [dhm_pkg::STAMP_W-1:0]   phase_start_r, phase_start_nxt;
  logic [dhm_pkg::STAMP_W-1:0]   elapsed;
  logic                          dwell_done;

  // elapsed time wraps modulo 2^32
  assign elapsed    = stamp_us - phase_start_r;
  assign dwell_done = elapsed >= dwell_us;

  // tentative states become final after the dwell time
  always_comb begin
    mode_nxt        = mode_r;
    phase_start_nxt = phase_start_r;
    case (mode_r)
      HM_CONSISTENT: begin
        if (cond.degen) begin
          mode_nxt        = HM_POT_INCONS;
          phase_start_nxt = stamp_us;
        end
      end
      HM_POT_INCONS: begin
        if (!cond.degen) begin
          mode_nxt = HM_CONSISTENT;
        end else if (dwell_done) begin
          mode_nxt = HM_INCONSISTENT;
        end
      end
      HM_INCONSISTENT: begin
        if (cond.recov) begin
          mode_nxt        = HM_POT_CONS;
          phase_start_nxt = stamp_us;
        end
      end
      HM_POT_CONS: begin
        if (!cond.recov) begin
          mode_nxt = HM_INCONSISTENT;
        end else if (dwell_done) begin
          mode_nxt = HM_CONSISTENT;
        end
      end
      default: begin
        mode_nxt = HM_CONSISTENT;
      end
    endcase
  end

  assign health_nxt = mode_nxt;

  // state and phase start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= HM_CONSISTENT;
      phase_start_r <= '0;
    end else if (step) begin
      mode_r        <= mode_nxt;
      phase_start_r <= phase_start_nxt;
    end
  end

endmodule

`default_nettype wire

[src/degeneracy_hysteresis_monitor.sv]
// Degeneracy hysteresis monitor.
// Input channel in_ch carries three signed Q23.8 eigenvalues and a microsecond
// timestamp; every accepted item yields exactly one result item on out_ch with
// the updated health state (0 consistent, 1 potentially inconsistent,
// 2 inconsistent, 3 potentially consistent) and the degenerated and recovered
// flags of that sample.
// An accepted item lands in the input register; once the output register is
// free, its result is written there and out_ch.valid rises. One item per cycle
// is sustained while out_ch.ready stays high: the history and health state
// update in the same cycle as the result register loads.
// Thresholds, dwell time and stagnation limit are written through the cfg_
// port by index; the user writes them only with no item in flight (unchecked).
// Reset (rst_n low, synchronous) empties both registers, restores the default
// thresholds and clears the history, run counter and health state.
// When out_ch.ready is low the result holds and the input register keeps one
// more item; in_ch.ready then drops until the output register drains.
`default_nettype none
`include "degeneracy_hysteresis_monitor_macros.svh"

module degeneracy_hysteresis_monitor #(
  parameter int VALUE_WIDTH    = dhm_pkg::VALUE_WIDTH_DEF,
  parameter int STAGNATION_EPS = dhm_pkg::STAGNATION_EPS_DEF,
  localparam int CfgW = (VALUE_WIDTH > dhm_pkg::DWELL_W) ? VALUE_WIDTH : dhm_pkg::DWELL_W
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  dhm_in_if.sink                                 in_ch,
  dhm_out_if.source                              out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [dhm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CfgW-1:0]                   cfg_wdata
);

  // configuration registers
  logic signed [VALUE_WIDTH-1:0]   low_x_r, low_y_r, low_z_r;
  logic signed [VALUE_WIDTH-1:0]   high_x_r, high_y_r, high_z_r;
  logic [dhm_pkg::DWELL_W-1:0]     dwell_r;
  logic [dhm_pkg::COUNT_W-1:0]     limit_r;

  // input register
  logic                            s1_valid_r;
  logic signed [VALUE_WIDTH-1:0]   s1_x_r, s1_y_r, s1_z_r;
  logic [dhm_pkg::STAMP_W-1:0]     s1_stamp_r;

  // output register
  logic                            out_valid_r;
  logic [dhm_pkg::HEALTH_W-1:0]    health_r;
  logic                            degen_r, recov_r;

  logic                            out_free, step, in_take;
  dhm_pkg::cond_t                  cond;
  logic [dhm_pkg::HEALTH_W-1:0]    health_nxt;

  // handshake
  assign out_free    = !out_valid_r || out_ch.ready;
  assign step        = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_take     = in_ch.valid && in_ch.ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_x_r  <= VALUE_WIDTH'(dhm_pkg::LOW_X_RST);
      low_y_r  <= VALUE_WIDTH'(dhm_pkg::LOW_Y_RST);
      low_z_r  <= VALUE_WIDTH'(dhm_pkg::LOW_Z_RST);
      high_x_r <= VALUE_WIDTH'(dhm_pkg::HIGH_X_RST);
      high_y_r <= VALUE_WIDTH'(dhm_pkg::HIGH_Y_RST);
      high_z_r <= VALUE_WIDTH'(dhm_pkg::HIGH_Z_RST);
      dwell_r  <= dhm_pkg::DWELL_RST;
      limit_r  <= dhm_pkg::LIMIT_RST;
    end else if (cfg_we) begin
      case (dhm_pkg::cfg_idx_t'(cfg_index))
        dhm_pkg::CFG_LOW_X:            low_x_r  <= cfg_wdata[VALUE_WIDTH-1:0];
        dhm_pkg::CFG_LOW_Y:            low_y_r  <= cfg_wdata[VALUE_WIDTH-1:0];
        dhm_pkg::CFG_LOW_Z:            low_z_r  <= cfg_wdata[VALUE_WIDTH-1:0];
        dhm_pkg::CFG_HIGH_X:           high_x_r <= cfg_wdata[VALUE_WIDTH-1:0];
        dhm_pkg::CFG_HIGH_Y:           high_y_r <= cfg_wdata[VALUE_WIDTH-1:0];
        dhm_pkg::CFG_HIGH_Z:           high_z_r <= cfg_wdata[VALUE_WIDTH-1:0];
        dhm_pkg::CFG_DWELL_US:         dwell_r  <= cfg_wdata[dhm_pkg::DWELL_W-1:0];
        dhm_pkg::CFG_STAGNATION_LIMIT: limit_r  <= cfg_wdata[dhm_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (step) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_x_r     <= in_ch.eigen_x;
      s1_y_r     <= in_ch.eigen_y;
      s1_z_r     <= in_ch.eigen_z;
      s1_stamp_r <= in_ch.stamp_us;
    end
  end

  // stagnation and threshold conditions
  dhm_cond #(
    .VALUE_WIDTH    (VALUE_WIDTH),
    .STAGNATION_EPS (STAGNATION_EPS)
  ) u_cond (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .x          (s1_x_r),
    .y          (s1_y_r),
    .z          (s1_z_r),
    .low_x      (low_x_r),
    .low_y      (low_y_r),
    .low_z      (low_z_r),
    .high_x     (high_x_r),
    .high_y     (high_y_r),
    .high_z     (high_z_r),
    .stag_limit (limit_r),
    .cond       (cond)
  );

  // health state machine
  dhm_health u_health (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .cond       (cond),
    .stamp_us   (s1_stamp_r),
    .dwell_us   (dwell_r),
    .health_nxt (health_nxt)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      health_r <= health_nxt;
      degen_r  <= cond.degen;
      recov_r  <= cond.recov;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.health      = health_r;
  assign out_ch.degenerated = degen_r;
  assign out_ch.recovered   = recov_r;

  // checks
  `DHM_ASSERT_NEXT(a_step_fills_out, clk, rst_n, step, out_valid_r,
                   "processed item did not reach the output register")
  `DHM_ASSERT_NEXT(a_take_fills_s1, clk, rst_n, in_take, s1_valid_r,
                   "accepted item did not reach the input register")
  `DHM_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !s1_valid_r, in_ch.ready,
                  "input stalled with an empty input register")

endmodule

`default_nettype wire

[test/testbench.sv]
module testbench;
  import dhm_pkg::*;

  localparam int DRAIN_CYCLES   = 4;
  localparam int LONG_HOLD      = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S_MIN = 32'h8000_0000;

  typedef enum logic [HEALTH_W-1:0] {
    H_CONSISTENT   = 2'd0,
    H_MAYBE_BAD    = 2'd1,
    H_INCONSISTENT = 2'd2,
    H_MAYBE_GOOD   = 2'd3
  } health_t;

  // kind of signal the random generator is currently producing
  typedef enum int {REG_DEGEN, REG_GOOD, REG_EDGE, REG_STILL} regime_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] stamp;
  } sample_t;

  typedef struct packed {
    health_t health;
    logic    degen;
    logic    recov;
  } verdict_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_wdata;

  dhm_in_if  in_if ();
  dhm_out_if out_if ();

  degeneracy_hysteresis_monitor u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // register copies and health state of the predictor
  logic signed [31:0] thr_lo [3];
  logic signed [31:0] thr_hi [3];
  logic [31:0]        dwell_us;
  logic [7:0]         stag_limit;
  health_t            mode;
  logic [31:0]        phase_t0;
  logic signed [31:0] last_val [3];
  logic [7:0]         still_run;

  sample_t  samples_to_send [$];
  verdict_t expected_health [$];

  // generator and pacing state
  regime_t     regime;
  logic [31:0] gen_last [3];
  logic [31:0] stamp_now;
  logic [31:0] stamp_step;
  bit          src_idle;
  bit          snk_idle;
  int          stall_token;
  int          errors;
  int          results_seen;

  // one sample through the stagnation counter, the two conditions and the health machine
  function automatic verdict_t advance_health(sample_t s);
    logic signed [31:0] v [3];
    longint             diff;
    logic               still;
    logic               degen;
    logic               recov;
    logic [31:0]        elapsed;
    verdict_t           r;
    v[0] = s.x;
    v[1] = s.y;
    v[2] = s.z;
    still = 1'b1;
    for (int k = 0; k < 3; k++) begin
      diff = longint'(v[k]) - longint'(last_val[k]);
      if (diff < 0) diff = -diff;
      if (diff >= STAGNATION_EPS_DEF) still = 1'b0;
    end

    // run of stagnant samples, only counted while x is above 0.1
    if (still && v[0] > X_MIN_LSB) begin
      if (still_run != COUNT_MAX) still_run++;
    end else begin
      still_run = '0;
    end
    for (int k = 0; k < 3; k++) last_val[k] = v[k];

    degen = (still_run >= stag_limit);
    recov = !still;
    for (int k = 0; k < 3; k++) begin
      if (v[k] < thr_lo[k]) degen = 1'b1;
      if (!(v[k] > thr_hi[k])) recov = 1'b0;
    end

    elapsed = s.stamp - phase_t0;
    case (mode)
      H_CONSISTENT: begin
        if (degen) begin
          mode = H_MAYBE_BAD;
          phase_t0 = s.stamp;
        end
      end
      H_MAYBE_BAD: begin
        if (!degen) mode = H_CONSISTENT;
        else if (elapsed >= dwell_us) mode = H_INCONSISTENT;
      end
      H_INCONSISTENT: begin
        if (recov) begin
          mode = H_MAYBE_GOOD;
          phase_t0 = s.stamp;
        end
      end
      H_MAYBE_GOOD: begin
        if (!recov) mode = H_INCONSISTENT;
        else if (elapsed >= dwell_us) mode = H_CONSISTENT;
      end
    endcase

    r.health = mode;
    r.degen  = degen;
    r.recov  = recov;
    return r;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap(bit on);
    int r;
    r = $urandom_range(0, 99);
    if (!on || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at result %0d, %s: got %0h, want %0h", results_seen, what, got, want);
    errors++;
  endtask

  task automatic set_reg(cfg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_LOW_X:            thr_lo[0] = val;
      CFG_LOW_Y:            thr_lo[1] = val;
      CFG_LOW_Z:            thr_lo[2] = val;
      CFG_HIGH_X:           thr_hi[0] = val;
      CFG_HIGH_Y:           thr_hi[1] = val;
      CFG_HIGH_Z:           thr_hi[2] = val;
      CFG_DWELL_US:         dwell_us = val;
      CFG_STAGNATION_LIMIT: stag_limit = val[7:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(logic [31:0] lx, logic [31:0] ly, logic [31:0] lz,
                         logic [31:0] hx, logic [31:0] hy, logic [31:0] hz,
                         logic [31:0] dwell, logic [7:0] limit);
    set_reg(CFG_LOW_X, lx);
    set_reg(CFG_LOW_Y, ly);
    set_reg(CFG_LOW_Z, lz);
    set_reg(CFG_HIGH_X, hx);
    set_reg(CFG_HIGH_Y, hy);
    set_reg(CFG_HIGH_Z, hz);
    set_reg(CFG_DWELL_US, dwell);
    set_reg(CFG_STAGNATION_LIMIT, {24'd0, limit});
  endtask

  task automatic add(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] stamp);
    samples_to_send.push_back('{x, y, z, stamp});
  endtask

  // random samples in persistent regimes so the health machine gets deep
  task automatic add_random(int count);
    logic [31:0] v [3];
    repeat (count) begin
      if ($urandom_range(0, 7) == 0) regime = regime_t'($urandom_range(0, 3));
      for (int k = 0; k < 3; k++) begin
        case (regime)
          REG_DEGEN: begin
            if ($urandom_range(0, 1) == 0) v[k] = thr_lo[k] - $urandom_range(1, 3000);
            else v[k] = thr_hi[k] + $urandom_range(0, 3000);
          end
          REG_GOOD:  v[k] = thr_hi[k] + $urandom_range(1, 3000);
          REG_EDGE: begin
            if ($urandom_range(0, 1) == 0) v[k] = thr_lo[k] + $urandom_range(0, 4) - 2;
            else v[k] = thr_hi[k] + $urandom_range(0, 4) - 2;
          end
          REG_STILL: begin
            v[k] = gen_last[k];
            if ($urandom_range(0, 11) == 0) v[k] = v[k] + $urandom_range(0, 2) - 1;
          end
        endcase
        if (regime != REG_STILL && $urandom_range(0, 9) == 0) v[k] = $urandom;
      end
      if ($urandom_range(0, 39) == 0) stamp_now = $urandom;
      else stamp_now = stamp_now + $urandom_range(0, stamp_step);
      gen_last = v;
      add(v[0], v[1], v[2], stamp_now);
    end
  endtask

  // sender stops until every result is back and the pipeline is empty
  // (checked at the falling edge so the driver's updates have settled)
  task automatic wait_idle();
    do @(negedge clk);
    while (samples_to_send.size() != 0 || in_if.valid || expected_health.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // input driver
  sample_t cur;
  int      src_gap;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) expected_health.push_back(advance_health(cur));
      if (!in_if.valid || in_if.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_if.valid <= 1'b0;
        end else if (samples_to_send.size() > 0) begin
          cur = samples_to_send.pop_front();
          in_if.eigen_x  <= cur.x;
          in_if.eigen_y  <= cur.y;
          in_if.eigen_z  <= cur.z;
          in_if.stamp_us <= cur.stamp;
          in_if.valid    <= 1'b1;
          src_gap = pick_gap(src_idle);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver pacing
  verdict_t want_v;
  int       hold_left;
  int       snk_gap;
  int       stall_seen;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_left = 0;
      snk_gap = 0;
      stall_seen = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_health.size() == 0) begin
          report_mismatch("result with nothing pending",
                          {out_if.health, out_if.degenerated, out_if.recovered}, '0);
        end else begin
          want_v = expected_health.pop_front();
          if (out_if.health !== want_v.health)
            report_mismatch("health", out_if.health, want_v.health);
          if (out_if.degenerated !== want_v.degen)
            report_mismatch("degenerated", out_if.degenerated, want_v.degen);
          if (out_if.recovered !== want_v.recov)
            report_mismatch("recovered", out_if.recovered, want_v.recov);
        end
        results_seen++;
      end

      // a long hold-off requested by the sequencer
      if (stall_token != stall_seen) begin
        stall_seen = stall_token;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        snk_gap = pick_gap(snk_idle);
      end
    end
  end

  // watchdog on cycles without any handshake
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL degeneracy_hysteresis_monitor");
      $finish;
    end
  end

  // sequencer
  logic [31:0] w [3];
  logic [31:0] rnd_lo [3];

  initial begin
    cfg_we         = 1'b0;
    cfg_index      = CFG_LOW_X;
    cfg_wdata      = '0;
    in_if.valid    = 1'b0;
    in_if.eigen_x  = '0;
    in_if.eigen_y  = '0;
    in_if.eigen_z  = '0;
    in_if.stamp_us = '0;
    out_if.ready   = 1'b0;

    thr_lo[0]  = LOW_X_RST;
    thr_lo[1]  = LOW_Y_RST;
    thr_lo[2]  = LOW_Z_RST;
    thr_hi[0]  = HIGH_X_RST;
    thr_hi[1]  = HIGH_Y_RST;
    thr_hi[2]  = HIGH_Z_RST;
    dwell_us   = DWELL_RST;
    stag_limit = LIMIT_RST;
    mode       = H_CONSISTENT;
    phase_t0   = '0;
    still_run  = '0;
    for (int k = 0; k < 3; k++) begin
      last_val[k] = '0;
      gen_last[k] = '0;
    end
    regime       = REG_GOOD;
    stamp_now    = '0;
    stamp_step   = 32'd1000;
    src_idle     = 1'b1;
    snk_idle     = 1'b1;
    stall_token  = 0;
    errors       = 0;
    results_seen = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed items on reset settings
    add(32'd0, 32'd0, 32'd0, 32'd0);                      // first sample against zero history
    add(S_MIN, S_MAX, 32'd0, 32'd100);
    add(S_MAX, S_MIN, 32'hFFFF_FFFF, 32'd399_999);        // one short of the dwell
    add(32'd100, 32'd100, 32'd100, 32'd400_000);          // dwell reached exactly
    add(S_MAX, S_MAX, S_MAX, 32'd400_010);
    add(S_MAX, S_MAX, S_MAX, 32'd400_020);                // repeat kills recovery
    add(32'd20000, 32'd20000, 32'd30000, 32'd500_000);
    add(32'd20001, 32'd20000, 32'd30000, 32'd900_000);    // one lsb apart is not stagnant
    for (int k = 0; k < 6; k++) add(32'd20001, 32'd20000, 32'd30000, 32'd900_100 + k);
    add(32'd25, 32'd20000, 32'd30000, 32'd900_200);
    add(32'd25, 32'd20000, 32'd30000, 32'd900_300);       // x at 0.1 does not count
    add(32'd26, 32'd20000, 32'd30000, 32'd900_400);
    add(32'd26, 32'd20000, 32'd30000, 32'd900_500);
    add(32'd10240, 32'd10240, 32'd17920, 32'hFFFF_FFF0);  // values on the low thresholds
    add(32'd15360, 32'd15360, 32'd23040, 32'd400_000);    // on the high thresholds, wrapped time
    add(32'd100, 32'd100, 32'd101, 32'd10);               // time runs backwards
    wait_idle();

    // thresholds near reset values, short dwell, timestamps about to wrap
    set_all(LOW_X_RST + $urandom_range(0, 1000) - 500, LOW_Y_RST + $urandom_range(0, 1000) - 500,
            LOW_Z_RST + $urandom_range(0, 1000) - 500, HIGH_X_RST + $urandom_range(0, 1000) - 500,
            HIGH_Y_RST + $urandom_range(0, 1000) - 500, HIGH_Z_RST + $urandom_range(0, 1000) - 500,
            32'd50, 8'd3);
    stamp_now  = 32'hFFFF_FF00;
    stamp_step = 32'd30;
    add_random(60);
    wait_idle();

    // zero limit and zero dwell: every sample degenerated
    set_all(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, 32'd0, 8'd0);
    stamp_step = 32'd5;
    add_random(30);
    wait_idle();

    // largest dwell: only an elapsed time of all ones qualifies
    set_all(S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MIN, 32'hFFFF_FFFF, 8'd255);
    add(S_MAX, S_MAX, S_MAX, 32'd4000);
    add(S_MAX, S_MAX, S_MAX, 32'd4000);
    add(32'd0, 32'd0, 32'd0, 32'd5000);
    add(32'd1, 32'd1, 32'd1, 32'd4999);
    stamp_step = 32'd1000;
    add_random(30);
    wait_idle();

    // long stagnant run up to counter saturation
    set_all(LOW_X_RST, LOW_Y_RST, LOW_Z_RST, S_MAX, S_MAX, S_MAX, 32'd20, 8'd255);
    for (int k = 0; k < 3; k++) w[k] = 32'd50000 + $urandom_range(0, 100000);
    repeat (262) begin
      stamp_now = stamp_now + $urandom_range(0, 10);
      add(w[0], w[1], w[2], stamp_now);
    end
    wait_idle();

    // back to reset values, sender never idles, receiver holds off for a long stretch
    set_all(LOW_X_RST, LOW_Y_RST, LOW_Z_RST, HIGH_X_RST, HIGH_Y_RST, HIGH_Z_RST,
            DWELL_RST, LIMIT_RST);
    stamp_step = 32'd150_000;
    src_idle   = 1'b0;
    add_random(80);
    repeat (6) @(posedge clk);
    stall_token++;
    wait_idle();

    // random thresholds, no idling on either side
    for (int k = 0; k < 3; k++) rnd_lo[k] = $urandom;
    set_all(rnd_lo[0], rnd_lo[1], rnd_lo[2], rnd_lo[0] + $urandom_range(0, 20000),
            rnd_lo[1] + $urandom_range(0, 20000), rnd_lo[2] + $urandom_range(0, 20000),
            $urandom_range(0, 200), $urandom_range(1, 8));
    stamp_step = 32'd100;
    snk_idle   = 1'b0;
    add_random(80);
    wait_idle();

    if (errors == 0) $display("PASS degeneracy_hysteresis_monitor");
    else $display("FAIL degeneracy_hysteresis_monitor");
    $finish;
  end

endmodule
